[rtl/csnr_pkg.sv]
// ----------------------------------------------------------------------------
// csnr_pkg
// Shared types, constants and helpers of the cubic Newton/bisection root finder.
// ----------------------------------------------------------------------------
package csnr_pkg;

	localparam int POS_W          = 32;
	localparam int WIDE_W         = 62;
	localparam int FRAC_W         = 24;
	localparam int TOL_W          = 31;
	localparam int MAX_ITERATIONS = 100;
	localparam int OUT_ITER_W     = 7;
	localparam int OUT_ITER_MAX   = (1 << OUT_ITER_W) - 1;
	localparam int ITER_W         = ($clog2(MAX_ITERATIONS + 1) > OUT_ITER_W) ?
		$clog2(MAX_ITERATIONS + 1) : OUT_ITER_W;
	localparam int LIMIT_ITERS    = (MAX_ITERATIONS > OUT_ITER_MAX) ?
		OUT_ITER_MAX : MAX_ITERATIONS;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic        [WIDE_W-1:0] umag_t;

	localparam wide_t WIDE_LIM = wide_t'((64'sd1 <<< 60) - 64'sd1);
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(17);

	typedef struct packed {
		pos_t coef_cubic;
		pos_t coef_square;
		pos_t coef_linear;
		pos_t coef_constant;
		pos_t bracket_low;
		pos_t bracket_high;
	} in_item_t;

	typedef struct packed {
		pos_t                  root;
		logic [1:0]            exit_kind;
		logic                  not_bracketed;
		logic [OUT_ITER_W-1:0] iterations_used;
	} out_item_t;

	typedef enum logic [1:0] {
		EXIT_ENDPOINT = 2'd0,
		EXIT_TOL      = 2'd1,
		EXIT_SAME     = 2'd2,
		EXIT_LIMIT    = 2'd3
	} exit_kind_t;

	typedef enum logic [1:0] {
		EV_FL = 2'd0,
		EV_FH = 2'd1,
		EV_F  = 2'd2,
		EV_DF = 2'd3
	} ev_kind_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_EV_INIT,
		OP_MUL_EV,
		OP_EV_ADD,
		OP_EV_STORE,
		OP_SETUP,
		OP_MUL_G1,
		OP_G1_STORE,
		OP_MUL_G2,
		OP_G2_STORE,
		OP_MUL_SL,
		OP_SL_STORE,
		OP_BISECT,
		OP_DIV,
		OP_NEWTON,
		OP_MOVE,
		OP_FIN
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EV_INIT,
		S_EV_MUL,
		S_EV_WAIT,
		S_EV_STORE,
		S_CHECK,
		S_MOVE,
		S_G1_MUL,
		S_G1_WAIT,
		S_G2_MUL,
		S_G2_WAIT,
		S_SL_MUL,
		S_SL_WAIT,
		S_DECIDE,
		S_DIV_WAIT,
		S_TEST,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t     op;
		ev_kind_t   ev_kind;
		logic [1:0] ev_step;
		exit_kind_t exit_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic fl_zero;
		logic fh_zero;
		logic outside;
		logic slow;
		logic same;
		logic tol_met;
		logic last_iter;
		logic mul_done;
		logic div_done;
	} dp_sts_t;

	function automatic umag_t mag_w(input wide_t v);
		mag_w = v[WIDE_W-1] ? umag_t'(-v) : umag_t'(v);
	endfunction

endpackage

[rtl/csnr_mul.sv]
// ----------------------------------------------------------------------------
// csnr_mul
// Sequential Q.24 multiplier: four 32x32 partial products, then shift and clamp.
// ----------------------------------------------------------------------------
module csnr_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  csnr_pkg::wide_t a,
	input  csnr_pkg::wide_t b,
	output logic           done,
	output csnr_pkg::wide_t res
);
	import csnr_pkg::*;

	localparam int ACC_W = 2 * WIDE_W;

	umag_t             am_q;
	umag_t             bm_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [1:0]        cnt_q;
	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	wide_t             res_q;

	logic [31:0]       a_h;
	logic [31:0]       b_h;
	logic [63:0]       prod;
	logic [1:0]        sh;
	logic [ACC_W-1:0]  prod_sh;
	logic              over;
	logic [63:0]       m;
	umag_t             mm;

	always_comb begin
		a_h     = cnt_q[0] ? {2'b00, am_q[WIDE_W-1:32]} : am_q[31:0];
		b_h     = cnt_q[1] ? {2'b00, bm_q[WIDE_W-1:32]} : bm_q[31:0];
		prod    = a_h * b_h;
		sh      = {cnt_q[0] & cnt_q[1], cnt_q[0] ^ cnt_q[1]};
		prod_sh = {{(ACC_W-64){1'b0}}, prod} << {sh, 5'b00000};
		over    = |acc_q[ACC_W-1:88];
		m       = acc_q[87:FRAC_W];
		if (over || (m > {2'b00, WIDE_LIM}))
			mm = umag_t'(WIDE_LIM);
		else
			mm = m[WIDE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= mag_w(a);
			bm_q  <= mag_w(b);
			neg_q <= a[WIDE_W-1] ^ b[WIDE_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + prod_sh;
		end
		if (fin_q)
			res_q <= neg_q ? -$signed(mm) : $signed(mm);
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/csnr_div.sv]
// ----------------------------------------------------------------------------
// csnr_div
// Restoring Q.24 divider, one quotient bit per cycle, clamped wide result.
// ----------------------------------------------------------------------------
module csnr_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  csnr_pkg::wide_t n,
	input  csnr_pkg::wide_t d,
	output logic           done,
	output csnr_pkg::wide_t quo
);
	import csnr_pkg::*;

	localparam int NUM_W = WIDE_W + FRAC_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  nq_q;
	umag_t             rem_q;
	umag_t             dm_q;
	logic              neg_q;
	logic              zero_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	wide_t             quo_q;

	logic [WIDE_W:0]   r2;
	logic [WIDE_W:0]   diff;
	logic              ge;
	umag_t             mm;

	always_comb begin
		r2   = {rem_q, nq_q[NUM_W-1]};
		diff = r2 - {1'b0, dm_q};
		ge   = r2 >= {1'b0, dm_q};
		if (zero_q)
			mm = '0;
		else if (|nq_q[NUM_W-1:60])
			mm = umag_t'(WIDE_LIM);
		else
			mm = {{(WIDE_W-60){1'b0}}, nq_q[59:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= (d != '0);
				fin_q  <= (d == '0);
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dm_q   <= mag_w(d);
			nq_q   <= {mag_w(n), {FRAC_W{1'b0}}};
			rem_q  <= '0;
			neg_q  <= n[WIDE_W-1] ^ d[WIDE_W-1];
			zero_q <= (d == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDE_W-1:0] : r2[WIDE_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
		if (fin_q)
			quo_q <= neg_q ? -$signed(mm) : $signed(mm);
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/csnr_dp.sv]
// ----------------------------------------------------------------------------
// csnr_dp
// Datapath: item registers, bracket, Horner evaluation, step update, result.
// ----------------------------------------------------------------------------
module csnr_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csnr_pkg::in_item_t    item,
	input  logic                  cfg_valid,
	input  logic [csnr_pkg::TOL_W-1:0] cfg_data,
	input  csnr_pkg::dp_cmd_t     cmd,
	output csnr_pkg::dp_sts_t     sts,
	output csnr_pkg::out_item_t   result
);
	import csnr_pkg::*;

	pos_t              k0_q, k1_q, k2_q, k3_q;
	pos_t              x1_q, x2_q, xl_q, xh_q, rts_q;
	wide_t             t_q, fl_q, fh_q, f_q, df_q;
	wide_t             g1_q, g2_q, msl_q, dx_q, dxold_q;
	logic              same_q;
	logic [ITER_W-1:0] iter_q;
	logic [TOL_W-1:0]  tol_q;
	out_item_t         res_q;

	pos_t              ex;
	wide_t             mul_a, mul_b, mul_res, quo, add_w, hs_sat;
	logic              mul_start, mul_done, div_start, div_done;
	logic signed [POS_W:0]  d_xh, d_xl, sx, sxr, mid, dd, hd, hdr, half, nr;
	logic [POS_W:0]    dmag;
	logic signed [WIDE_W:0] hs, lim63, ns;
	pos_t              nr2;
	logic              nb;
	logic [OUT_ITER_W-1:0] iters_out;

	csnr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
	);

	csnr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(f_q), .d(df_q), .done(div_done), .quo(quo)
	);

	always_comb begin
		unique case (cmd.ev_kind)
			EV_FL: ex = x1_q;
			EV_FH: ex = x2_q;
			EV_F, EV_DF: ex = rts_q;
			default: ex = rts_q;
		endcase

		d_xh = {rts_q[POS_W-1], rts_q} - {xh_q[POS_W-1], xh_q};
		d_xl = {rts_q[POS_W-1], rts_q} - {xl_q[POS_W-1], xl_q};

		mul_a     = t_q;
		mul_b     = {{(WIDE_W-POS_W){ex[POS_W-1]}}, ex};
		mul_start = 1'b0;
		case (cmd.op)
			OP_MUL_EV: mul_start = 1'b1;
			OP_MUL_G1: begin
				mul_start = 1'b1;
				mul_a     = {{(WIDE_W-POS_W-1){d_xh[POS_W]}}, d_xh};
				mul_b     = df_q;
			end
			OP_MUL_G2: begin
				mul_start = 1'b1;
				mul_a     = {{(WIDE_W-POS_W-1){d_xl[POS_W]}}, d_xl};
				mul_b     = df_q;
			end
			OP_MUL_SL: begin
				mul_start = 1'b1;
				mul_a     = dxold_q;
				mul_b     = df_q;
			end
			default: ;
		endcase
		div_start = (cmd.op == OP_DIV);

		case (cmd.ev_step)
			2'd0: begin
				if (cmd.ev_kind == EV_DF)
					add_w = {{(WIDE_W-POS_W-1){k1_q[POS_W-1]}}, k1_q, 1'b0};
				else
					add_w = {{(WIDE_W-POS_W){k1_q[POS_W-1]}}, k1_q};
			end
			2'd1: add_w = {{(WIDE_W-POS_W){k2_q[POS_W-1]}}, k2_q};
			default: add_w = {{(WIDE_W-POS_W){k3_q[POS_W-1]}}, k3_q};
		endcase
		hs    = {mul_res[WIDE_W-1], mul_res} + {add_w[WIDE_W-1], add_w};
		lim63 = {1'b0, WIDE_LIM};
		if (hs > lim63)
			hs_sat = WIDE_LIM;
		else if (hs < -lim63)
			hs_sat = -WIDE_LIM;
		else
			hs_sat = hs[WIDE_W-1:0];

		sx   = {x1_q[POS_W-1], x1_q} + {x2_q[POS_W-1], x2_q};
		sxr  = sx + {{POS_W{1'b0}}, sx[POS_W]};
		mid  = sxr >>> 1;
		dd   = {x2_q[POS_W-1], x2_q} - {x1_q[POS_W-1], x1_q};
		dmag = dd[POS_W] ? -dd : dd;

		hd   = {xh_q[POS_W-1], xh_q} - {xl_q[POS_W-1], xl_q};
		hdr  = hd + {{POS_W{1'b0}}, hd[POS_W]};
		half = hdr >>> 1;
		nr   = {xl_q[POS_W-1], xl_q} + half;

		ns = {{(WIDE_W-POS_W+1){rts_q[POS_W-1]}}, rts_q} - {quo[WIDE_W-1], quo};
		if (ns > $signed({{(WIDE_W-POS_W+2){1'b0}}, {(POS_W-1){1'b1}}}))
			nr2 = {1'b0, {(POS_W-1){1'b1}}};
		else if (ns < $signed({{(WIDE_W-POS_W+2){1'b1}}, {(POS_W-1){1'b0}}}))
			nr2 = {1'b1, {(POS_W-1){1'b0}}};
		else
			nr2 = ns[POS_W-1:0];

		nb = ((fl_q > 0) && (fh_q > 0)) || (fl_q[WIDE_W-1] && fh_q[WIDE_W-1]);
		if (iter_q > ITER_W'(OUT_ITER_MAX))
			iters_out = OUT_ITER_W'(OUT_ITER_MAX);
		else
			iters_out = iter_q[OUT_ITER_W-1:0];
	end

	always_comb begin
		sts.fl_zero   = (fl_q == '0);
		sts.fh_zero   = (fh_q == '0);
		sts.outside   = ((g1_q > 0) && (g2_q > 0)) || (g1_q[WIDE_W-1] && g2_q[WIDE_W-1]);
		sts.slow      = {mag_w(f_q), 1'b0} > {1'b0, mag_w(msl_q)};
		sts.same      = same_q;
		sts.tol_met   = mag_w(dx_q) < {{(WIDE_W-TOL_W){1'b0}}, tol_q};
		sts.last_iter = (iter_q == ITER_W'(MAX_ITERATIONS));
		sts.mul_done  = mul_done;
		sts.div_done  = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TOL_RESET;
		else if (cfg_valid)
			tol_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				k0_q <= item.coef_cubic;
				k1_q <= item.coef_square;
				k2_q <= item.coef_linear;
				k3_q <= item.coef_constant;
				x1_q <= item.bracket_low;
				x2_q <= item.bracket_high;
			end
			OP_EV_INIT: begin
				if (cmd.ev_kind == EV_DF)
					t_q <= {{(WIDE_W-POS_W){k0_q[POS_W-1]}}, k0_q}
						+ {{(WIDE_W-POS_W-1){k0_q[POS_W-1]}}, k0_q, 1'b0};
				else
					t_q <= {{(WIDE_W-POS_W){k0_q[POS_W-1]}}, k0_q};
			end
			OP_EV_ADD: t_q <= hs_sat;
			OP_EV_STORE: begin
				unique case (cmd.ev_kind)
					EV_FL: fl_q <= t_q;
					EV_FH: fh_q <= t_q;
					EV_F:  f_q  <= t_q;
					EV_DF: df_q <= t_q;
					default: ;
				endcase
			end
			OP_SETUP: begin
				if (fl_q[WIDE_W-1]) begin
					xl_q <= x1_q;
					xh_q <= x2_q;
				end else begin
					xl_q <= x2_q;
					xh_q <= x1_q;
				end
				rts_q   <= mid[POS_W-1:0];
				dx_q    <= {{(WIDE_W-POS_W-1){1'b0}}, dmag};
				dxold_q <= {{(WIDE_W-POS_W-1){1'b0}}, dmag};
				iter_q  <= ITER_W'(1);
			end
			OP_G1_STORE: g1_q  <= mul_res - f_q;
			OP_G2_STORE: g2_q  <= mul_res - f_q;
			OP_SL_STORE: msl_q <= mul_res;
			OP_BISECT: begin
				dxold_q <= dx_q;
				dx_q    <= {{(WIDE_W-POS_W-1){half[POS_W]}}, half};
				rts_q   <= nr[POS_W-1:0];
				same_q  <= (half == '0);
			end
			OP_NEWTON: begin
				dxold_q <= dx_q;
				dx_q    <= quo;
				rts_q   <= nr2;
				same_q  <= (nr2 == rts_q);
			end
			OP_MOVE: begin
				if (f_q[WIDE_W-1])
					xl_q <= rts_q;
				else
					xh_q <= rts_q;
				iter_q <= iter_q + ITER_W'(1);
			end
			OP_FIN: begin
				unique case (cmd.exit_kind)
					EXIT_ENDPOINT: begin
						res_q.root            <= (fl_q == '0) ? x1_q : x2_q;
						res_q.iterations_used <= '0;
					end
					EXIT_LIMIT: begin
						res_q.root            <= '0;
						res_q.iterations_used <= iters_out;
					end
					EXIT_TOL, EXIT_SAME: begin
						res_q.root            <= rts_q;
						res_q.iterations_used <= iters_out;
					end
					default: ;
				endcase
				res_q.exit_kind     <= cmd.exit_kind;
				res_q.not_bracketed <= nb;
			end
			default: ;
		endcase
	end

	assign result = res_q;

endmodule

[rtl/csnr_ctrl.sv]
// ----------------------------------------------------------------------------
// csnr_ctrl
// Sequencer: handshakes, Horner steps, Newton/bisection loop, result register.
// ----------------------------------------------------------------------------
module csnr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	output logic               result_valid,
	input  logic               result_ready,
	input  csnr_pkg::dp_sts_t  sts,
	output csnr_pkg::dp_cmd_t  cmd
);
	import csnr_pkg::*;

	ctrl_state_t state_q, state_d;
	ev_kind_t    ev_kind_q, ev_kind_d;
	logic [1:0]  step_q, step_d;
	logic        loop_q, loop_d;
	exit_kind_t  exit_q, exit_d;
	logic        out_valid_q;
	logic        fin_go;
	logic        ev_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ev_kind_q   <= EV_FL;
			step_q      <= '0;
			loop_q      <= 1'b0;
			exit_q      <= EXIT_ENDPOINT;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ev_kind_q <= ev_kind_d;
			step_q    <= step_d;
			loop_q    <= loop_d;
			exit_q    <= exit_d;
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		ev_kind_d = ev_kind_q;
		step_d    = step_q;
		loop_d    = loop_q;
		exit_d    = exit_q;
		fin_go    = 1'b0;
		cmd.op        = OP_NONE;
		cmd.ev_kind   = ev_kind_q;
		cmd.ev_step   = step_q;
		cmd.exit_kind = exit_q;
		ev_last = (ev_kind_q == EV_DF) ? (step_q == 2'd1) : (step_q == 2'd2);

		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.op    = OP_LOAD;
					ev_kind_d = EV_FL;
					state_d   = S_EV_INIT;
				end
			end
			S_EV_INIT: begin
				cmd.op  = OP_EV_INIT;
				step_d  = '0;
				state_d = S_EV_MUL;
			end
			S_EV_MUL: begin
				cmd.op  = OP_MUL_EV;
				state_d = S_EV_WAIT;
			end
			S_EV_WAIT: begin
				if (sts.mul_done) begin
					cmd.op = OP_EV_ADD;
					if (ev_last) begin
						state_d = S_EV_STORE;
					end else begin
						step_d  = step_q + 2'd1;
						state_d = S_EV_MUL;
					end
				end
			end
			S_EV_STORE: begin
				cmd.op = OP_EV_STORE;
				unique case (ev_kind_q)
					EV_FL: begin
						ev_kind_d = EV_FH;
						state_d   = S_EV_INIT;
					end
					EV_FH: state_d = S_CHECK;
					EV_F: begin
						ev_kind_d = EV_DF;
						state_d   = S_EV_INIT;
					end
					EV_DF: state_d = loop_q ? S_MOVE : S_G1_MUL;
					default: state_d = S_IDLE;
				endcase
			end
			S_CHECK: begin
				if (sts.fl_zero || sts.fh_zero) begin
					exit_d  = EXIT_ENDPOINT;
					state_d = S_FIN;
				end else begin
					cmd.op    = OP_SETUP;
					ev_kind_d = EV_F;
					loop_d    = 1'b0;
					state_d   = S_EV_INIT;
				end
			end
			S_MOVE: begin
				if (sts.last_iter) begin
					exit_d  = EXIT_LIMIT;
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_MOVE;
					state_d = S_G1_MUL;
				end
			end
			S_G1_MUL: begin
				cmd.op  = OP_MUL_G1;
				state_d = S_G1_WAIT;
			end
			S_G1_WAIT: begin
				if (sts.mul_done) begin
					cmd.op  = OP_G1_STORE;
					state_d = S_G2_MUL;
				end
			end
			S_G2_MUL: begin
				cmd.op  = OP_MUL_G2;
				state_d = S_G2_WAIT;
			end
			S_G2_WAIT: begin
				if (sts.mul_done) begin
					cmd.op  = OP_G2_STORE;
					state_d = S_SL_MUL;
				end
			end
			S_SL_MUL: begin
				cmd.op  = OP_MUL_SL;
				state_d = S_SL_WAIT;
			end
			S_SL_WAIT: begin
				if (sts.mul_done) begin
					cmd.op  = OP_SL_STORE;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.outside || sts.slow) begin
					cmd.op  = OP_BISECT;
					state_d = S_TEST;
				end else begin
					cmd.op  = OP_DIV;
					state_d = S_DIV_WAIT;
				end
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.op  = OP_NEWTON;
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (sts.same) begin
					exit_d  = EXIT_SAME;
					state_d = S_FIN;
				end else if (sts.tol_met) begin
					exit_d  = EXIT_TOL;
					state_d = S_FIN;
				end else begin
					ev_kind_d = EV_F;
					loop_d    = 1'b1;
					state_d   = S_EV_INIT;
				end
			end
			S_FIN: begin
				if (!out_valid_q || result_ready) begin
					cmd.op  = OP_FIN;
					fin_go  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

endmodule

[rtl/cubic_safeguarded_newton_root.sv]
// ----------------------------------------------------------------------------
// cubic_safeguarded_newton_root
// Cubic root search by Newton-Raphson with bisection fallback, Q8.24.
//
//  channel | direction | payload      | transfer when
//  item    | in        | in_item_t    | item_valid & item_ready
//  result  | out       | out_item_t   | result_valid & result_ready
//  cfg     | in        | tolerance    | cfg_valid & cfg_ready
//
// endpoint and step evaluations run on the sequential four-product multiplier;
// a Newton step also uses the 86-step divider, and the search ends at the
// iteration limit at the latest
// one item in flight; the next item is taken while a result waits
// reset returns to idle with the tolerance at its reset value
// ----------------------------------------------------------------------------
module cubic_safeguarded_newton_root (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  csnr_pkg::in_item_t         item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output csnr_pkg::out_item_t        result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [csnr_pkg::TOL_W-1:0] cfg_data
);
	import csnr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	csnr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.result_valid(result_valid), .result_ready(result_ready),
		.sts(sts), .cmd(cmd)
	);

	csnr_dp u_dp (
		.clk(clk), .arst_n(arst_n), .item(item),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .result(result)
	);

	assign cfg_ready = 1'b1;

endmodule

[rtl/csnr_chk.sv]
// ----------------------------------------------------------------------------
// csnr_chk
// Port-level checks of the root finder, bound to the top level.
// ----------------------------------------------------------------------------
module csnr_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input csnr_pkg::in_item_t         item,
	input logic                       result_valid,
	input logic                       result_ready,
	input csnr_pkg::out_item_t        result,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [csnr_pkg::TOL_W-1:0] cfg_data
);
	import csnr_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while busy");

	a_endpoint_iters: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.exit_kind == EXIT_ENDPOINT |-> result.iterations_used == '0)
		else $error("endpoint exit with iterations");

	a_loop_iters: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.exit_kind != EXIT_ENDPOINT |-> result.iterations_used != '0)
		else $error("loop exit without iterations");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.exit_kind == EXIT_LIMIT |->
		result.root == '0 && result.iterations_used == OUT_ITER_W'(LIMIT_ITERS))
		else $error("iteration limit result malformed");

endmodule

bind cubic_safeguarded_newton_root csnr_chk u_csnr_chk (.*);

[tb/sv/cubic_safeguarded_newton_root_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_safeguarded_newton_root_test
// Drives cubic coefficient sets and brackets into the root finder and checks
// every result field against a bit-accurate model of the safeguarded Newton
// search, across several tolerance settings with random idling on both sides.
// ----------------------------------------------------------------------------
module cubic_safeguarded_newton_root_test;
	import csnr_pkg::*;

	localparam longint LIM = 64'sd1152921504606846975;
	localparam int WATCHDOG = 200000;

	class root_scoreboard;
		out_item_t expected_roots[$];
		int mismatches;

		function void note_item(input out_item_t r);
			expected_roots.push_back(r);
		endfunction

		function void check_result(input out_item_t got);
			out_item_t want;
			if (expected_roots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = expected_roots.pop_front();
			if (got.root !== want.root || got.exit_kind !== want.exit_kind ||
				got.not_bracketed !== want.not_bracketed ||
				got.iterations_used !== want.iterations_used) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
						want.root, want.exit_kind, want.not_bracketed,
						want.iterations_used, got.root, got.exit_kind,
						got.not_bracketed, got.iterations_used);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 0;
	out_item_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [TOL_W-1:0] cfg_data = '0;

	root_scoreboard board = new();
	longint unsigned tol_model = 17;
	int idle_pct = 26;
	int stall_count;
	bit done = 0;

	cubic_safeguarded_newton_root u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint sat_wide(input longint v);
		if (v > LIM) return LIM;
		if (v < -LIM) return -LIM;
		return v;
	endfunction

	function automatic longint sat_pos(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint signed_of(input longint unsigned m, input bit neg);
		if (m > LIM) m = LIM;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint qmul(input longint p, input longint q);
		logic [127:0] prod;
		prod = 128'(mag(p)) * 128'(mag(q));
		prod = prod >> FRAC_W;
		if (prod > 128'(LIM)) prod = 128'(LIM);
		return signed_of(prod[63:0], (p < 0) != (q < 0));
	endfunction

	function automatic longint qdiv(input longint n, input longint d);
		logic [127:0] q;
		if (d == 0) return 0;
		q = (128'(mag(n)) << FRAC_W) / 128'(mag(d));
		if (q > 128'(LIM)) q = 128'(LIM);
		return signed_of(q[63:0], (n < 0) != (d < 0));
	endfunction

	function automatic longint cubic_at(input longint k[4], input longint x);
		longint t;
		t = k[0];
		t = sat_wide(qmul(t, x) + k[1]);
		t = sat_wide(qmul(t, x) + k[2]);
		return sat_wide(qmul(t, x) + k[3]);
	endfunction

	function automatic longint slope_at(input longint k[4], input longint x);
		longint t;
		t = 3 * k[0];
		t = sat_wide(qmul(t, x) + 2 * k[1]);
		return sat_wide(qmul(t, x) + k[2]);
	endfunction

	function automatic out_item_t predict_root(input in_item_t it);
		longint k[4];
		longint x1, x2, fl, fh, xl, xh, rts, dx, dxold, f, df, g1, g2, prev, rt;
		exit_kind_t kind;
		int iters;
		bit outside, slow, stop;
		out_item_t r;
		k[0] = it.coef_cubic;
		k[1] = it.coef_square;
		k[2] = it.coef_linear;
		k[3] = it.coef_constant;
		x1 = it.bracket_low;
		x2 = it.bracket_high;
		fl = cubic_at(k, x1);
		fh = cubic_at(k, x2);
		r.not_bracketed = (fl > 0 && fh > 0) || (fl < 0 && fh < 0);
		rt = 0;
		kind = EXIT_LIMIT;
		iters = 0;
		if (fl == 0) begin
			rt = x1;
			kind = EXIT_ENDPOINT;
		end else if (fh == 0) begin
			rt = x2;
			kind = EXIT_ENDPOINT;
		end else begin
			if (fl < 0) begin
				xl = x1; xh = x2;
			end else begin
				xl = x2; xh = x1;
			end
			rts = (x1 + x2) / 2;
			dxold = mag(x2 - x1);
			dx = dxold;
			f = cubic_at(k, rts);
			df = slope_at(k, rts);
			iters = MAX_ITERATIONS;
			stop = 0;
			for (int j = 1; j <= MAX_ITERATIONS && !stop; j++) begin
				g1 = qmul(rts - xh, df) - f;
				g2 = qmul(rts - xl, df) - f;
				outside = (g1 > 0 && g2 > 0) || (g1 < 0 && g2 < 0);
				slow = mag(2 * f) > mag(qmul(dxold, df));
				if (outside || slow) begin
					dxold = dx;
					dx = (xh - xl) / 2;
					rts = xl + dx;
					if (xl == rts) begin
						kind = EXIT_SAME; stop = 1;
					end
				end else begin
					prev = rts;
					dxold = dx;
					dx = qdiv(f, df);
					rts = sat_pos(rts - dx);
					if (prev == rts) begin
						kind = EXIT_SAME; stop = 1;
					end
				end
				if (!stop && mag(dx) < tol_model) begin
					kind = EXIT_TOL; stop = 1;
				end
				if (stop) begin
					rt = rts; iters = j;
				end else begin
					f = cubic_at(k, rts);
					df = slope_at(k, rts);
					if (f < 0) xl = rts;
					else xh = rts;
				end
			end
		end
		if (iters > 127) iters = 127;
		r.root = rt[31:0];
		r.exit_kind = kind;
		r.iterations_used = iters[6:0];
		return r;
	endfunction

	function automatic logic [31:0] q824(input int whole);
		return 32'(whole) << FRAC_W;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				board.note_item(predict_root(item));
			if (result_valid && result_ready)
				board.check_result(result);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready))
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			result_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (stall_count >= WATCHDOG && !done) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input in_item_t it);
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1;
		item <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain();
		item_valid <= 0;
		while (board.expected_roots.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		tol_model = v;
	endtask

	function automatic in_item_t make_poly(input logic [31:0] a, b, c, d, lo, hi);
		in_item_t it;
		it.coef_cubic = a; it.coef_square = b; it.coef_linear = c;
		it.coef_constant = d; it.bracket_low = lo; it.bracket_high = hi;
		return it;
	endfunction

	function automatic in_item_t random_poly();
		in_item_t it;
		int r1, r2, lo, hi;
		if ($urandom_range(9) < 2)
			return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r1 = $urandom_range(0, 12) - 6;
		r2 = $urandom_range(0, 12) - 6;
		// (x - r1)(x - r2)(x - 1) with small integer roots, then random tweaks to the constant and the cubic sign
		it.coef_cubic = q824(1);
		it.coef_square = -q824(r1 + r2 + 1);
		it.coef_linear = q824(r1 * r2 + r1 + r2);
		it.coef_constant = -q824(r1 * r2) + ($urandom_range(1) ? $urandom_range(0, 1 << 20) : 0);
		if ($urandom_range(1)) it.coef_cubic = -it.coef_cubic;
		lo = $urandom_range(0, 16) - 8;
		hi = $urandom_range(0, 16) - 8;
		it.bracket_low = q824(lo) + $urandom_range(0, 1 << 23);
		it.bracket_high = q824(hi) - $urandom_range(0, 1 << 23);
		return it;
	endfunction

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			send_item(random_poly());
	endtask

	initial begin
		logic [31:0] mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: exact endpoints, no sign change, zero slope, extremes
		send_item(make_poly(q824(1), 0, 0, -q824(1), q824(1), q824(2)));
		send_item(make_poly(q824(1), 0, 0, -q824(8), 0, q824(2)));
		send_item(make_poly(q824(1), 0, 0, -q824(2), 0, q824(2)));
		send_item(make_poly(q824(1), 0, 0, q824(1), q824(1), q824(3)));
		send_item(make_poly(0, 0, 0, q824(3), -q824(1), q824(1)));
		send_item(make_poly(0, q824(1), 0, -q824(1), -q824(1), q824(1)));
		send_item(make_poly(0, 0, q824(1), -q824(1), q824(3), -q824(2)));
		send_item(make_poly(mx, mx, mx, mx, mn, mx));
		send_item(make_poly(mn, mn, mn, mn, mn, mx));
		send_item(make_poly(mx, mn, mx, mn, mx, mn));
		send_item(make_poly(0, 0, 1, mn, mn, mx));
		send_item(make_poly(0, 0, 0, 0, mn, mx));
		send_item(make_poly(32'hffffffff, 0, 0, 1, 0, 32'hffffffff));
		send_item(make_poly(q824(1), 0, -q824(2), 0, q824(1), q824(2)));
		send_item(make_poly(0, 0, 32'h1, -32'h1, mn, mx));
		drain();

		idle_pct = 0;
		run_random(40);
		idle_pct = 26;
		write_tolerance('0);
		run_random(60);
		write_tolerance(31'h7fffffff);
		run_random(40);
		write_tolerance(31'd1 << 16);
		run_random(80);
		write_tolerance(31'd17);
		run_random(80);

		drain();
		done = 1;
		if (board.mismatches == 0 && board.expected_roots.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
